FILE: hw/rtl/xlb_pkg.sv
// Shared types, constants and a helper function for the XOR linear basis block.
package xlb_pkg;

  // Word width of the basis; the stored words and the reduction run at this width.
  localparam int unsigned Width = 32;
  localparam int unsigned IdxW  = $clog2(Width);
  localparam int unsigned CntW  = $clog2(Width + 1);

  typedef logic [Width-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [2:0] {
    OpAdd    = 3'd0,
    OpCheck  = 3'd1,
    OpReduce = 3'd2,
    OpMax    = 3'd3,
    OpClear  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StFin  = 3'b100
  } state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        flag;
  } out_item_t;

  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    word_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } ram_req_t;

  // Fold one stored word into the running value: keep the smaller for a
  // reduction, the larger for the max query.
  function automatic word_t fold_word(input logic is_max, input word_t acc, input word_t w);
    word_t t;
    t = acc ^ w;
    if (is_max) begin
      fold_word = (t > acc) ? t : acc;
    end else begin
      fold_word = (t < acc) ? t : acc;
    end
  endfunction

endpackage

FILE: hw/rtl/xlb_ram.sv
// Basis word store: one write port, one read port, registered read data.
module xlb_ram
  import xlb_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output word_t    rd_data_o
);

  word_t mem [Width];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/xlb_ctrl.sv
// Sequencer and accumulator: walks the stored words and builds each result.
module xlb_ctrl
  import xlb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  in_i,
  output logic      busy_o,
  output logic      done_o,
  output out_item_t out_o,
  output ram_req_t  ram_req_o,
  input  word_t     ram_rd_data_i
);

  state_e    state_q, state_d;
  cnt_t      count_q, count_d;
  cnt_t      idx_q, idx_d;
  logic      rdv_q, rdv_d;
  logic      done_q, done_d;
  logic [2:0] op_q, op_d;
  word_t     acc_q, acc_d;
  out_item_t out_q, out_d;
  logic      issue;
  logic      is_max;
  logic      walk_op;
  logic      append;

  assign is_max = (op_q == OpMax);
  assign issue  = (idx_q < count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rdv_d     = 1'b0;
    done_d    = 1'b0;
    op_d      = op_q;
    acc_d     = acc_q;
    out_d     = out_q;
    walk_op   = 1'b0;
    append    = 1'b0;
    ram_req_o = '0;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          op_d  = in_i.operation;
          idx_d = '0;
          acc_d = (in_i.operation == OpMax) ? '0 : word_t'(in_i.value);
          unique case (in_i.operation) inside
            OpAdd, OpCheck, OpReduce, OpMax: walk_op = 1'b1;
            default:                         walk_op = 1'b0;
          endcase
          state_d = (walk_op && (count_q != '0)) ? StWalk : StFin;
        end
      end
      StWalk: begin
        // Issue one read per cycle; fold each word in the cycle after its read.
        ram_req_o.rd_en   = issue;
        ram_req_o.rd_addr = idx_q[IdxW-1:0];
        rdv_d             = issue;
        if (issue) begin
          idx_d = idx_q + cnt_t'(1);
        end
        if (rdv_q) begin
          acc_d = fold_word(is_max, acc_q, ram_rd_data_i);
        end
        if (!issue) begin
          state_d = StFin;
        end
      end
      StFin: begin
        done_d             = 1'b1;
        out_d.result_value = '0;
        out_d.flag         = 1'b0;
        unique case (op_q) inside
          OpAdd: begin
            append             = (acc_q != '0) && (count_q < cnt_t'(Width));
            out_d.result_value = 32'(acc_q);
            out_d.flag         = append;
          end
          OpCheck: begin
            out_d.result_value = 32'(acc_q);
            out_d.flag         = (acc_q == '0);
          end
          OpReduce, OpMax: begin
            out_d.result_value = 32'(acc_q);
          end
          OpClear: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
        // Append at the tail; no read of this entry can be in flight.
        ram_req_o.wr_en   = append;
        ram_req_o.wr_addr = count_q[IdxW-1:0];
        ram_req_o.wr_data = acc_q;
        if (append) begin
          count_d = count_q + cnt_t'(1);
        end
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      idx_q   <= '0;
      rdv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      rdv_q   <= rdv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    out_q <= out_d;
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

FILE: hw/rtl/xor_linear_basis_top.sv
// Top level of the XOR linear basis block over GF(2).
//
//   channel | ports                  | handshake
//   --------+------------------------+------------------------------------------
//   in      | start, busy, in_i      | item taken at a clock edge with start & !busy
//   out     | done_o, out_o          | one-cycle strobe, taken at the next edge
//
// Add, check, reduce and max items walk the stored words before their done_o
// strobe; count, the number of stored words, is up to 32. Clear, unused codes
// and an empty basis skip the walk. The walk reads one stored word per cycle
// from the single read port of the basis memory, and that read sets the rate.
// Reset clears the word count and the sequencer; the word memory needs no
// clearing since only entries below the count are ever read.
// The receiver cannot stall: done_o marks each result on out_o for one cycle only.
// busy drops in the cycle done_o rises, so the next item may start there.
module xor_linear_basis_top
  import xlb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_i,
  output logic      done_o,
  output out_item_t out_o
);

  ram_req_t ram_req;
  word_t    ram_rd_data;

  // Sequence the walk, fold words into the running value, update the count.
  xlb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .in_i          (in_i),
    .busy_o        (busy),
    .done_o        (done_o),
    .out_o         (out_o),
    .ram_req_o     (ram_req),
    .ram_rd_data_i (ram_rd_data)
  );

  // Hold the basis words in insertion order.
  xlb_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd_data)
  );

endmodule

FILE: hw/rtl/xlb_checker.sv
// Port-level checker for the XOR linear basis top level, with its bind.
module xlb_checker
  import xlb_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_item_t  in_i,
  input logic      done_o,
  input out_item_t out_o
);

  logic accept;
  assign accept = start && !busy;

  // A result strobe only follows a busy cycle and leaves the block idle.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result strobe without a preceding busy cycle");

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after accepting an item");

  // Strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result strobes in consecutive cycles");

  // Clear and unused codes (every code above max) pass through the finish
  // state and then strobe a result of zero with no flag.
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.operation > OpMax))
    |=> ##1 (done_o && (out_o.result_value == '0) && !out_o.flag))
    else $error("clear or unused code gave a wrong or late result");

endmodule

bind xor_linear_basis_top xlb_checker u_xlb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .in_i   (in_i),
  .done_o (done_o),
  .out_o  (out_o)
);

FILE: tb/tb_top.sv
// Self-checking regression bench for the GF(2) xor linear basis block.
module tb_top;
  import xlb_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned DrainCycles = Width + 8;

  // Operation codes the block does not define; they must leave the basis alone.
  localparam logic [2:0] OpSpareA = 3'd5;
  localparam logic [2:0] OpSpareB = 3'd6;
  localparam logic [2:0] OpSpareC = 3'd7;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  in_item_t  in_i   = '0;
  logic      busy;
  logic      done_o;
  out_item_t out_o;

  xor_linear_basis_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .out_o  (out_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the basis, advanced on every accepted item.
  word_t       shadow_words [Width];
  int unsigned shadow_count = 0;

  out_item_t   pending_results [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;

  function automatic in_item_t make_item(input logic [2:0] op, input logic [31:0] v);
    in_item_t it;
    it.operation = op;
    it.value     = v;
    return it;
  endfunction

  // Walk the stored words in order, keeping value ^ word whenever it is smaller.
  function automatic word_t reduce_by_basis(input word_t v);
    word_t acc;
    acc = v;
    for (int i = 0; i < shadow_count; i++) begin
      if ((acc ^ shadow_words[i]) < acc) acc = acc ^ shadow_words[i];
    end
    return acc;
  endfunction

  // Greedy maximum xor, taken in insertion order.
  function automatic word_t greedy_max_xor();
    word_t acc;
    acc = '0;
    for (int i = 0; i < shadow_count; i++) begin
      if ((acc ^ shadow_words[i]) > acc) acc = acc ^ shadow_words[i];
    end
    return acc;
  endfunction

  // Compute the expected result of one accepted item and update the shadow basis.
  task automatic predict_item(input in_item_t it);
    out_item_t exp_res;
    word_t     v;
    word_t     red;
    v       = word_t'(it.value);
    red     = '0;
    exp_res = '0;
    case (it.operation)
      OpAdd: begin
        red = reduce_by_basis(v);
        if (red != '0 && shadow_count < Width) begin
          shadow_words[shadow_count] = red;
          shadow_count++;
          exp_res.flag = 1'b1;
        end
      end
      OpCheck: begin
        red          = reduce_by_basis(v);
        exp_res.flag = (red == '0);
      end
      OpReduce: red = reduce_by_basis(v);
      OpMax:    red = greedy_max_xor();
      OpClear:  shadow_count = 0;
      default:  red = '0;
    endcase
    exp_res.result_value = 32'(red);
    pending_results = {pending_results, exp_res};
  endtask

  // Present one item and hold it until the block takes it. Items go out in
  // bursts; start drops only between bursts, never in the step it rises.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 45) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    start <= 1'b1;
    in_i  <= it;
    do @(posedge clk_i); while (busy);
    predict_item(it);
  endtask

  // XOR of a random subset of the stored words: always representable.
  function automatic word_t span_sample();
    word_t acc;
    acc = '0;
    for (int i = 0; i < shadow_count; i++) begin
      if ($urandom_range(0, 1) == 1) acc = acc ^ shadow_words[i];
    end
    return acc;
  endfunction

  function automatic logic [31:0] random_value();
    word_t w;
    case ($urandom_range(0, 9))
      0:       w = word_t'($urandom()) >> $urandom_range(0, Width - 1);
      1:       w = word_t'(1) << $urandom_range(0, Width - 1);
      2:       w = '1;
      3:       w = '0;
      4:       w = span_sample() ^ (word_t'(1) << $urandom_range(0, Width - 1));
      default: w = word_t'($urandom());
    endcase
    return 32'(w);
  endfunction

  // Compare every strobed result with the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h flag=%b", $time,
                 out_o.result_value, out_o.flag);
        error_count++;
      end else begin
        if (out_o.result_value !== pending_results[0].result_value) begin
          $display("%0t: result_value mismatch: expected %h, actual %h", $time,
                   pending_results[0].result_value, out_o.result_value);
          error_count++;
        end
        if (out_o.flag !== pending_results[0].flag) begin
          $display("%0t: flag mismatch: expected %b, actual %b", $time,
                   pending_results[0].flag, out_o.flag);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("xor_linear_basis_top regression: fail");
      $finish;
    end
  end

  // Empty basis: reduce and check see the value itself, max gives zero,
  // adding zero appends nothing.
  task automatic test_empty_basis();
    send_item(make_item(OpClear, 32'hFFFF_FFFF));
    send_item(make_item(OpReduce, 32'hFFFF_FFFF));
    send_item(make_item(OpCheck, 32'h0000_0000));
    send_item(make_item(OpCheck, 32'h8000_0000));
    send_item(make_item(OpMax, 32'h1234_5678));
    send_item(make_item(OpAdd, 32'h0000_0000));
  endtask

  // Extreme words, duplicates and a representable check.
  task automatic test_extremes();
    send_item(make_item(OpAdd, 32'hFFFF_FFFF));
    send_item(make_item(OpAdd, 32'h8000_0000));
    send_item(make_item(OpAdd, 32'h0000_0001));
    send_item(make_item(OpAdd, 32'hFFFF_FFFF));
    send_item(make_item(OpCheck, 32'h7FFF_FFFF));
    send_item(make_item(OpCheck, 32'h7FFF_FFFE));
    send_item(make_item(OpReduce, 32'hFFFF_FFFE));
    send_item(make_item(OpMax, 32'h0000_0000));
  endtask

  // Undefined codes return zero and leave the basis as it was.
  task automatic test_unused_codes();
    send_item(make_item(OpSpareA, 32'hFFFF_FFFF));
    send_item(make_item(OpSpareB, 32'h0000_0000));
    send_item(make_item(OpSpareC, 32'hA5A5_5A5A));
    send_item(make_item(OpMax, 32'hFFFF_FFFF));
    send_item(make_item(OpClear, 32'h0000_0000));
    send_item(make_item(OpMax, 32'h0000_0000));
  endtask

  // Fill the basis to Width words, then add, check and query a full basis.
  task automatic test_full_basis();
    word_t w;
    for (int i = Width - 1; i >= 0; i--) begin
      w = (word_t'(1) << i) | (word_t'($urandom()) & ((word_t'(1) << i) - 1));
      send_item(make_item(OpAdd, 32'(w)));
    end
    send_item(make_item(OpAdd, $urandom()));
    send_item(make_item(OpAdd, 32'hFFFF_FFFF));
    send_item(make_item(OpCheck, $urandom()));
    send_item(make_item(OpReduce, $urandom()));
    send_item(make_item(OpMax, 32'h0000_0000));
    send_item(make_item(OpClear, 32'h0000_0000));
  endtask

  // Mostly adds and queries against a growing basis, with clears and noise.
  task automatic test_random_mix();
    int unsigned pick;
    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(0, 99);
      if (shadow_count == Width && $urandom_range(0, 3) == 0) pick = 85;
      if (pick < 35)      send_item(make_item(OpAdd, random_value()));
      else if (pick < 48) send_item(make_item(OpCheck, random_value()));
      else if (pick < 58) send_item(make_item(OpCheck, 32'(span_sample())));
      else if (pick < 70) send_item(make_item(OpReduce, random_value()));
      else if (pick < 80) send_item(make_item(OpMax, $urandom()));
      else if (pick < 84) send_item(make_item(OpAdd, 32'(span_sample())));
      else if (pick < 89) send_item(make_item(OpClear, $urandom()));
      else if (pick < 94) send_item(make_item(3'($urandom_range(OpSpareA, OpSpareC)), $urandom()));
      else                send_item(make_item(OpAdd, $urandom()));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_basis();
    test_extremes();
    test_unused_codes();
    test_full_basis();
    test_random_mix();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("xor_linear_basis_top regression: pass");
    end else begin
      $display("xor_linear_basis_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/xlb_pkg.sv
hw/rtl/xlb_ram.sv
hw/rtl/xlb_ctrl.sv
hw/rtl/xor_linear_basis_top.sv
hw/rtl/xlb_checker.sv
tb/tb_top.sv
